@@ rtl/core/bcot_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// bcot_pkg: shared types and test selector codes for the overlap tester
// depends on nothing

package bcot_pkg;

    typedef logic [2:0] func_t;

    localparam func_t FUNC_POINT_BOX     = 3'd0;
    localparam func_t FUNC_BOX_BOX       = 3'd1;
    localparam func_t FUNC_BOX_CIRCLE    = 3'd2;
    localparam func_t FUNC_POINT_CIRCLE  = 3'd3;
    localparam func_t FUNC_CIRCLE_CIRCLE = 3'd4;

endpackage

`default_nettype wire

@@ rtl/core/box_circle_overlap_tester_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// box_circle_overlap_tester_unit: five stage overlap test between two shapes
// an accepted word passes the registers of stages 1 to 4 and then the output stage, which drives out_valid
// throughput: one word per cycle; each full stage holds while the stage after it is full and stalled
// reset: valid bits of all stages clear, so the pipeline comes up empty
// depends on bcot_pkg

module box_circle_overlap_tester_unit #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire bcot_pkg::func_t         func,
    input  wire logic                    check_exist,
    input  wire logic [COORD_BITS-1:0]   a_x,
    input  wire logic [COORD_BITS-1:0]   a_y,
    input  wire logic [COORD_BITS-2:0]   a_w,
    input  wire logic [COORD_BITS-2:0]   a_h,
    input  wire logic                    a_exist,
    input  wire logic [COORD_BITS-1:0]   b_x,
    input  wire logic [COORD_BITS-1:0]   b_y,
    input  wire logic [COORD_BITS-2:0]   b_w,
    input  wire logic [COORD_BITS-2:0]   b_h,
    input  wire logic                    b_exist,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         hit
);

    import bcot_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int EW = COORD_BITS - 1;
    localparam int SW = 2 * COORD_BITS;

    // stage enables
    logic en1, en2, en3, en4, en5;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;

    // stage 1: center deltas and per-test thresholds
    logic [CW:0]   s1_dx_reg, s1_dy_reg;
    logic [EW-1:0] s1_ex_reg, s1_ey_reg;
    logic [CW-1:0] s1_r_reg;
    logic [CW-1:0] s1_tx0_reg, s1_ty0_reg, s1_tx1_reg, s1_ty1_reg;
    logic          s1_use_box_reg, s1_use_circ_reg;

    logic [CW:0]   s1_dx_next, s1_dy_next;
    logic [EW-1:0] s1_ex_next, s1_ey_next;
    logic [CW-1:0] s1_r_next;
    logic [CW-1:0] s1_tx0_next, s1_ty0_next, s1_tx1_next, s1_ty1_next;
    logic          s1_use_box_next, s1_use_circ_next;

    // stage 2: box result and corner offsets
    logic          s2_box_hit_reg, s2_use_circ_reg;
    logic [CW-1:0] s2_r_reg;
    logic [CW+1:0] s2_x0_reg, s2_x1_reg, s2_y0_reg, s2_y1_reg;

    logic          s2_box_hit_next;
    logic [CW+1:0] s2_x0_next, s2_x1_next, s2_y0_next, s2_y1_next;

    // stage 3: corner magnitudes and range flags
    logic          s3_box_hit_reg, s3_use_circ_reg;
    logic [CW-1:0] s3_r_reg;
    logic [CW-1:0] s3_mx0_reg, s3_mx1_reg, s3_my0_reg, s3_my1_reg;
    logic [3:0]    s3_lt_reg;

    logic [CW-1:0] s3_mx0_next, s3_mx1_next, s3_my0_next, s3_my1_next;
    logic [3:0]    s3_lt_next;

    // stage 4: squares
    logic          s4_box_hit_reg, s4_use_circ_reg;
    logic [3:0]    s4_lt_reg;
    logic [SW-1:0] s4_x0_sq_reg, s4_x1_sq_reg, s4_y0_sq_reg, s4_y1_sq_reg, s4_r_sq_reg;

    logic [SW-1:0] s4_x0_sq_next, s4_x1_sq_next, s4_y0_sq_next, s4_y1_sq_next, s4_r_sq_next;

    // stage 5: output
    logic hit_reg, hit_next;

    assign en5 = !out_valid_reg || !out_stall;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign in_stall  = !en1;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    always_comb
    begin
        logic [CW-1:0] aw_e, ah_e, bw_e, bh_e;
        logic          b_is_point, kill;

        aw_e = {1'b0, a_w};
        ah_e = {1'b0, a_h};
        bw_e = {1'b0, b_w};
        bh_e = {1'b0, b_h};

        s1_dx_next = {a_x[CW-1], a_x} - {b_x[CW-1], b_x};
        s1_dy_next = {a_y[CW-1], a_y} - {b_y[CW-1], b_y};

        b_is_point = (func == FUNC_POINT_BOX) || (func == FUNC_POINT_CIRCLE);
        kill       = check_exist && (!a_exist || (!b_is_point && !b_exist));

        s1_ex_next       = '0;
        s1_ey_next       = '0;
        s1_r_next        = '0;
        s1_tx0_next      = aw_e;
        s1_ty0_next      = ah_e;
        s1_tx1_next      = aw_e;
        s1_ty1_next      = ah_e;
        s1_use_box_next  = 1'b0;
        s1_use_circ_next = 1'b0;

        unique case (func)
            FUNC_POINT_BOX:
            begin
                s1_use_box_next = 1'b1;
            end
            FUNC_BOX_BOX:
            begin
                s1_tx0_next     = aw_e + bw_e;
                s1_ty0_next     = ah_e + bh_e;
                s1_tx1_next     = aw_e + bw_e;
                s1_ty1_next     = ah_e + bh_e;
                s1_use_box_next = 1'b1;
            end
            FUNC_BOX_CIRCLE:
            begin
                s1_ty0_next      = ah_e + bw_e;
                s1_tx1_next      = aw_e + bw_e;
                s1_ex_next       = a_w;
                s1_ey_next       = a_h;
                s1_r_next        = bw_e;
                s1_use_box_next  = 1'b1;
                s1_use_circ_next = 1'b1;
            end
            FUNC_POINT_CIRCLE:
            begin
                s1_r_next        = aw_e;
                s1_use_circ_next = 1'b1;
            end
            FUNC_CIRCLE_CIRCLE:
            begin
                s1_r_next        = aw_e + bw_e;
                s1_use_circ_next = 1'b1;
            end
            default:
            begin
                s1_use_box_next  = 1'b0;
                s1_use_circ_next = 1'b0;
            end
        endcase

        if (kill)
        begin
            s1_use_box_next  = 1'b0;
            s1_use_circ_next = 1'b0;
        end
    end

    always_comb
    begin
        logic [CW:0]   abs_dx, abs_dy;
        logic [CW+1:0] dx_w, dy_w, ex_w, ey_w;

        abs_dx = s1_dx_reg[CW] ? (~s1_dx_reg + 1'b1) : s1_dx_reg;
        abs_dy = s1_dy_reg[CW] ? (~s1_dy_reg + 1'b1) : s1_dy_reg;

        s2_box_hit_next = s1_use_box_reg &&
            ((abs_dx <= {1'b0, s1_tx0_reg} && abs_dy <= {1'b0, s1_ty0_reg}) ||
             (abs_dx <= {1'b0, s1_tx1_reg} && abs_dy <= {1'b0, s1_ty1_reg}));

        dx_w = {s1_dx_reg[CW], s1_dx_reg};
        dy_w = {s1_dy_reg[CW], s1_dy_reg};
        ex_w = {3'b000, s1_ex_reg};
        ey_w = {3'b000, s1_ey_reg};

        s2_x0_next = dx_w - ex_w;
        s2_x1_next = dx_w + ex_w;
        s2_y0_next = dy_w - ey_w;
        s2_y1_next = dy_w + ey_w;
    end

    always_comb
    begin
        logic [CW+1:0] mx0, mx1, my0, my1, r_w;

        mx0 = s2_x0_reg[CW+1] ? (~s2_x0_reg + 1'b1) : s2_x0_reg;
        mx1 = s2_x1_reg[CW+1] ? (~s2_x1_reg + 1'b1) : s2_x1_reg;
        my0 = s2_y0_reg[CW+1] ? (~s2_y0_reg + 1'b1) : s2_y0_reg;
        my1 = s2_y1_reg[CW+1] ? (~s2_y1_reg + 1'b1) : s2_y1_reg;
        r_w = {2'b00, s2_r_reg};

        // magnitudes at or above the radius rule the corner out
        s3_lt_next  = {my1 < r_w, my0 < r_w, mx1 < r_w, mx0 < r_w};
        s3_mx0_next = mx0[CW-1:0];
        s3_mx1_next = mx1[CW-1:0];
        s3_my0_next = my0[CW-1:0];
        s3_my1_next = my1[CW-1:0];
    end

    always_comb
    begin
        s4_x0_sq_next = SW'(s3_mx0_reg) * SW'(s3_mx0_reg);
        s4_x1_sq_next = SW'(s3_mx1_reg) * SW'(s3_mx1_reg);
        s4_y0_sq_next = SW'(s3_my0_reg) * SW'(s3_my0_reg);
        s4_y1_sq_next = SW'(s3_my1_reg) * SW'(s3_my1_reg);
        s4_r_sq_next  = SW'(s3_r_reg) * SW'(s3_r_reg);
    end

    always_comb
    begin
        logic [SW:0] r2;
        logic        c00, c01, c10, c11;

        r2  = {1'b0, s4_r_sq_reg};
        c00 = s4_lt_reg[0] && s4_lt_reg[2] &&
              (({1'b0, s4_x0_sq_reg} + {1'b0, s4_y0_sq_reg}) < r2);
        c01 = s4_lt_reg[0] && s4_lt_reg[3] &&
              (({1'b0, s4_x0_sq_reg} + {1'b0, s4_y1_sq_reg}) < r2);
        c10 = s4_lt_reg[1] && s4_lt_reg[2] &&
              (({1'b0, s4_x1_sq_reg} + {1'b0, s4_y0_sq_reg}) < r2);
        c11 = s4_lt_reg[1] && s4_lt_reg[3] &&
              (({1'b0, s4_x1_sq_reg} + {1'b0, s4_y1_sq_reg}) < r2);

        hit_next = s4_box_hit_reg || (s4_use_circ_reg && (c00 || c01 || c10 || c11));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_dx_reg       <= s1_dx_next;
            s1_dy_reg       <= s1_dy_next;
            s1_ex_reg       <= s1_ex_next;
            s1_ey_reg       <= s1_ey_next;
            s1_r_reg        <= s1_r_next;
            s1_tx0_reg      <= s1_tx0_next;
            s1_ty0_reg      <= s1_ty0_next;
            s1_tx1_reg      <= s1_tx1_next;
            s1_ty1_reg      <= s1_ty1_next;
            s1_use_box_reg  <= s1_use_box_next;
            s1_use_circ_reg <= s1_use_circ_next;
        end
        if (en2)
        begin
            s2_box_hit_reg  <= s2_box_hit_next;
            s2_use_circ_reg <= s1_use_circ_reg;
            s2_r_reg        <= s1_r_reg;
            s2_x0_reg       <= s2_x0_next;
            s2_x1_reg       <= s2_x1_next;
            s2_y0_reg       <= s2_y0_next;
            s2_y1_reg       <= s2_y1_next;
        end
        if (en3)
        begin
            s3_box_hit_reg  <= s2_box_hit_reg;
            s3_use_circ_reg <= s2_use_circ_reg;
            s3_r_reg        <= s2_r_reg;
            s3_mx0_reg      <= s3_mx0_next;
            s3_mx1_reg      <= s3_mx1_next;
            s3_my0_reg      <= s3_my0_next;
            s3_my1_reg      <= s3_my1_next;
            s3_lt_reg       <= s3_lt_next;
        end
        if (en4)
        begin
            s4_box_hit_reg  <= s3_box_hit_reg;
            s4_use_circ_reg <= s3_use_circ_reg;
            s4_lt_reg       <= s3_lt_reg;
            s4_x0_sq_reg    <= s4_x0_sq_next;
            s4_x1_sq_reg    <= s4_x1_sq_next;
            s4_y0_sq_reg    <= s4_y0_sq_next;
            s4_y1_sq_reg    <= s4_y1_sq_next;
            s4_r_sq_reg     <= s4_r_sq_next;
        end
        if (en5)
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for box_circle_overlap_tester_unit, directed overlap cases
// then random near and wide shape pairs under random idling and a long output hold-off
// depends on bcot_pkg and box_circle_overlap_tester_unit

module tb_top;

    import bcot_pkg::*;

    localparam int CB           = 16;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLDOFF_LEN  = 80;

    typedef struct {
        func_t            func;
        logic             check_exist;
        logic [CB-1:0]    a_x;
        logic [CB-1:0]    a_y;
        logic [CB-2:0]    a_w;
        logic [CB-2:0]    a_h;
        logic             a_exist;
        logic [CB-1:0]    b_x;
        logic [CB-1:0]    b_y;
        logic [CB-2:0]    b_w;
        logic [CB-2:0]    b_h;
        logic             b_exist;
    } query_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    func_t         func;
    logic          check_exist;
    logic [CB-1:0] a_x;
    logic [CB-1:0] a_y;
    logic [CB-2:0] a_w;
    logic [CB-2:0] a_h;
    logic          a_exist;
    logic [CB-1:0] b_x;
    logic [CB-1:0] b_y;
    logic [CB-2:0] b_w;
    logic [CB-2:0] b_h;
    logic          b_exist;
    logic          out_valid;
    logic          out_stall;
    logic          hit;

    logic          expected_hits[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    bit            quiet          = 0;
    bit            holdoff_go     = 0;
    int            holdoff_left   = 0;

    box_circle_overlap_tester_unit #(
        .COORD_BITS(CB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .check_exist(check_exist),
        .a_x(a_x),
        .a_y(a_y),
        .a_w(a_w),
        .a_h(a_h),
        .a_exist(a_exist),
        .b_x(b_x),
        .b_y(b_y),
        .b_w(b_w),
        .b_h(b_h),
        .b_exist(b_exist),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit box_holds(longint cx, longint cy, longint w, longint h,
                                     longint px, longint py);
        return (cx - w <= px) && (px <= cx + w) && (cy - h <= py) && (py <= cy + h);
    endfunction

    // strict: dx^2 + dy^2 < r^2
    function automatic bit disc_holds(longint dx, longint dy, longint r);
        longint mx;
        longint my;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        if (mx >= r || my >= r)
            return 1'b0;
        return my * my < r * r - mx * mx;
    endfunction

    function automatic logic overlap_of(query_t q);
        longint ax;
        longint ay;
        longint aw;
        longint ah;
        longint bx;
        longint by;
        longint bw;
        longint bh;
        bit     b_point;
        ax = $signed(q.a_x);
        ay = $signed(q.a_y);
        bx = $signed(q.b_x);
        by = $signed(q.b_y);
        aw = q.a_w;
        ah = q.a_h;
        bw = q.b_w;
        bh = q.b_h;
        b_point = (q.func == FUNC_POINT_BOX) || (q.func == FUNC_POINT_CIRCLE);
        if (q.check_exist && (!q.a_exist || (!b_point && !q.b_exist)))
            return 1'b0;
        case (q.func)
            FUNC_POINT_BOX:
                return box_holds(ax, ay, aw, ah, bx, by);
            FUNC_BOX_BOX:
                return (ax - aw <= bx + bw) && (bx - bw <= ax + aw) &&
                       (ay - ah <= by + bh) && (by - bh <= ay + ah);
            FUNC_BOX_CIRCLE:
                return box_holds(ax, ay, aw, ah + bw, bx, by) ||
                       box_holds(ax, ay, aw + bw, ah, bx, by) ||
                       disc_holds(ax - aw - bx, ay - ah - by, bw) ||
                       disc_holds(ax - aw - bx, ay + ah - by, bw) ||
                       disc_holds(ax + aw - bx, ay - ah - by, bw) ||
                       disc_holds(ax + aw - bx, ay + ah - by, bw);
            FUNC_POINT_CIRCLE:
                return disc_holds(bx - ax, by - ay, aw);
            FUNC_CIRCLE_CIRCLE:
                return disc_holds(bx - ax, by - ay, aw + bw);
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // result check and prediction of every accepted word
    always @(posedge clk)
    begin
        query_t q;
        logic   want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("result word with nothing pending");
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit !== want)
                        report_mismatch($sformatf("hit got %b want %b", hit, want));
                end
            end
            if (in_valid && !in_stall)
            begin
                q.func        = func;
                q.check_exist = check_exist;
                q.a_x         = a_x;
                q.a_y         = a_y;
                q.a_w         = a_w;
                q.a_h         = a_h;
                q.a_exist     = a_exist;
                q.b_x         = b_x;
                q.b_y         = b_y;
                q.b_w         = b_w;
                q.b_h         = b_h;
                q.b_exist     = b_exist;
                expected_hits.push_back(overlap_of(q));
            end
        end
    end

    // receiver stall: random, quiet, or a counted hold-off
    always @(posedge clk)
    begin
        if (holdoff_go)
        begin
            holdoff_go   = 0;
            holdoff_left = HOLDOFF_LEN;
        end
        if (holdoff_left > 0)
        begin
            out_stall <= 1'b1;
            holdoff_left--;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 7);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic query_t make_query(func_t f, logic chk,
                                          int ax, int ay, int aw, int ah, logic ae,
                                          int bx, int by, int bw, int bh, logic be);
        query_t q;
        q.func        = f;
        q.check_exist = chk;
        q.a_x         = ax[CB-1:0];
        q.a_y         = ay[CB-1:0];
        q.a_w         = aw[CB-2:0];
        q.a_h         = ah[CB-2:0];
        q.a_exist     = ae;
        q.b_x         = bx[CB-1:0];
        q.b_y         = by[CB-1:0];
        q.b_w         = bw[CB-2:0];
        q.b_h         = bh[CB-2:0];
        q.b_exist     = be;
        return q;
    endfunction

    // called right after a rising edge; returns at the edge that takes the word
    task automatic send_query(query_t q);
        if (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func        <= q.func;
        check_exist <= q.check_exist;
        a_x         <= q.a_x;
        a_y         <= q.a_y;
        a_w         <= q.a_w;
        a_h         <= q.a_h;
        a_exist     <= q.a_exist;
        b_x         <= q.b_x;
        b_y         <= q.b_y;
        b_w         <= q.b_w;
        b_h         <= q.b_h;
        b_exist     <= q.b_exist;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic int rand_extent();
        if ($urandom_range(0, 99) < 10)
            return $urandom_range(0, 32767);
        return $urandom_range(0, 2047);
    endfunction

    // shapes placed close together so both hits and misses are common
    function automatic query_t rand_near_query();
        query_t q;
        int     base_x;
        int     base_y;
        int     aw;
        int     ah;
        int     bw;
        int     bh;
        int     span;
        base_x = int'($urandom_range(0, 40000)) - 20000;
        base_y = int'($urandom_range(0, 40000)) - 20000;
        aw = rand_extent();
        ah = rand_extent();
        bw = rand_extent();
        bh = rand_extent();
        span = aw + ah + bw + bh + 16;
        q = make_query(func_t'($urandom_range(0, 99) < 92 ? $urandom_range(0, 4)
                                                         : $urandom_range(5, 7)),
                       1'($urandom_range(0, 1)),
                       base_x, base_y, aw, ah, ($urandom_range(0, 99) < 85),
                       base_x + int'($urandom_range(0, 2 * span)) - span,
                       base_y + int'($urandom_range(0, 2 * span)) - span,
                       bw, bh, ($urandom_range(0, 99) < 85));
        return q;
    endfunction

    function automatic query_t rand_wide_query();
        return make_query(func_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 32767), $urandom_range(0, 32767),
                          1'($urandom_range(0, 1)),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 32767), $urandom_range(0, 32767),
                          1'($urandom_range(0, 1)));
    endfunction

    task automatic test_point_box();
        send_query(make_query(FUNC_POINT_BOX, 1, 0, 0, 16, 16, 1, 16, -16, 0, 0, 1));
        send_query(make_query(FUNC_POINT_BOX, 1, 0, 0, 16, 16, 1, 17, 0, 0, 0, 1));
        send_query(make_query(FUNC_POINT_BOX, 0, -32768, 32767, 32767, 32767, 1,
                              32767, -32768, 32767, 32767, 1));
        send_query(make_query(FUNC_POINT_BOX, 0, 32767, -32768, 32767, 32767, 1,
                              -1, -1, 0, 0, 0));
    endtask

    task automatic test_box_box();
        send_query(make_query(FUNC_BOX_BOX, 1, 0, 0, 10, 10, 1, 20, 0, 10, 10, 1));
        send_query(make_query(FUNC_BOX_BOX, 1, 0, 0, 10, 10, 1, 21, 0, 10, 10, 1));
        send_query(make_query(FUNC_BOX_BOX, 0, -32768, -32768, 32767, 32767, 1,
                              32767, 32767, 32767, 32767, 1));
        send_query(make_query(FUNC_BOX_BOX, 0, -32768, 0, 0, 0, 1, 32767, 0, 0, 0, 1));
    endtask

    task automatic test_box_circle();
        send_query(make_query(FUNC_BOX_CIRCLE, 1, 0, 0, 10, 10, 1, 15, 0, 5, 0, 1));
        send_query(make_query(FUNC_BOX_CIRCLE, 1, 0, 0, 10, 10, 1, 0, -15, 5, 0, 1));
        send_query(make_query(FUNC_BOX_CIRCLE, 1, 0, 0, 10, 10, 1, 13, 13, 5, 0, 1));
        send_query(make_query(FUNC_BOX_CIRCLE, 1, 0, 0, 10, 10, 1, -14, -14, 5, 0, 1));
        send_query(make_query(FUNC_BOX_CIRCLE, 0, 32767, 32767, 32767, 32767, 1,
                              -32768, -32768, 32767, 32767, 1));
    endtask

    task automatic test_circle_pairs();
        send_query(make_query(FUNC_POINT_CIRCLE, 1, 0, 0, 5, 0, 1, 3, 4, 0, 0, 1));
        send_query(make_query(FUNC_POINT_CIRCLE, 1, 0, 0, 5, 0, 1, -3, -3, 0, 0, 1));
        send_query(make_query(FUNC_POINT_CIRCLE, 1, 100, 100, 0, 0, 1, 100, 100, 0, 0, 1));
        send_query(make_query(FUNC_CIRCLE_CIRCLE, 1, 0, 0, 4, 0, 1, 6, 8, 6, 0, 1));
        send_query(make_query(FUNC_CIRCLE_CIRCLE, 1, 0, 0, 4, 0, 1, 6, 7, 6, 0, 1));
        send_query(make_query(FUNC_CIRCLE_CIRCLE, 0, -32768, -32768, 32767, 0, 1,
                              32767, 32767, 32767, 0, 1));
    endtask

    task automatic test_exist_and_unused();
        send_query(make_query(FUNC_BOX_BOX, 1, 0, 0, 10, 10, 0, 0, 0, 10, 10, 1));
        send_query(make_query(FUNC_POINT_BOX, 1, 0, 0, 10, 10, 1, 0, 0, 0, 0, 0));
        send_query(make_query(FUNC_BOX_BOX, 1, 0, 0, 10, 10, 1, 0, 0, 10, 10, 0));
        send_query(make_query(FUNC_CIRCLE_CIRCLE, 0, 0, 0, 10, 0, 0, 0, 0, 10, 0, 0));
        send_query(make_query(func_t'(5), 0, 0, 0, 10, 10, 1, 0, 0, 10, 10, 1));
        send_query(make_query(func_t'(6), 0, 0, 0, 10, 10, 1, 0, 0, 10, 10, 1));
        send_query(make_query(func_t'(7), 1, 0, 0, 10, 10, 1, 0, 0, 10, 10, 1));
    endtask

    // output held off while words keep coming, so the pipe fills and stalls its input
    task automatic test_input_backpressure();
        holdoff_go = 1;
        repeat (40) send_query(rand_near_query());
    endtask

    task automatic test_random_near(int count);
        repeat (count) send_query(rand_near_query());
    endtask

    task automatic test_random_wide(int count);
        repeat (count) send_query(rand_wide_query());
    endtask

    task automatic test_random_no_idle(int count);
        quiet = 1;
        repeat (count) send_query(($urandom_range(0, 3) == 0) ? rand_wide_query()
                                                              : rand_near_query());
        quiet = 0;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_POINT_BOX;
        check_exist <= 1'b0;
        a_x         <= '0;
        a_y         <= '0;
        a_w         <= '0;
        a_h         <= '0;
        a_exist     <= 1'b0;
        b_x         <= '0;
        b_y         <= '0;
        b_w         <= '0;
        b_h         <= '0;
        b_exist     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_point_box();
        test_box_box();
        test_box_circle();
        test_circle_pairs();
        test_exist_and_unused();
        test_input_backpressure();
        test_random_near(600);
        test_random_wide(150);
        test_random_no_idle(120);
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
